// File: sv/xyg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the rate table for the XY pad vector glide block.
package xyg_pkg;

    // Position format: unsigned fixed point, 1.0 = 2^POS_FRAC_BITS.
    localparam int POS_FRAC_BITS = 22;
    localparam int POS_W         = POS_FRAC_BITS + 1;
    // Width of squared distances and of the square root work registers.
    localparam int VW            = 2 * POS_W;
    // Multiplier operand widths.
    localparam int MA            = 32;
    localparam int MB            = (POS_W > 14) ? POS_W : 14;
    localparam int MP            = MA + MB;
    // Step scaling: step = (rate_q4 * tick_period) >> STEP_SHIFT.
    localparam int STEP_SHIFT    = 36 - POS_FRAC_BITS;
    localparam int SW            = POS_FRAC_BITS + 10;
    // Iteration counter for the square root and the divider.
    localparam int CNT_W         = $clog2(POS_W + 1);

    // Item kinds.
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_PAD   = 2'd1;
    localparam logic [1:0] KIND_SCENE = 2'd2;

    // Configuration register indexes.
    localparam int          REG_IDX_W       = 1;
    localparam logic [0:0]  REG_TICK_PERIOD = 1'd0;
    localparam logic [0:0]  REG_PULSE_TICKS = 1'd1;

    localparam logic [31:0] TICK_PERIOD_RESET = 32'd89478;
    localparam logic [15:0] PULSE_TICKS_RESET = 16'd48;
    localparam logic [2:0]  RATE_CHOICE_RESET = 3'd2;

    // Glide rates times 16, indexed by scene number.
    localparam logic [13:0] RATE_Q4 [8] = '{
        14'd16000, 14'd128, 14'd32, 14'd16, 14'd8, 14'd4, 14'd2, 14'd1
    };

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] index;
        logic       pressed;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] cursor_x;
        logic [POS_W-1:0] cursor_y;
        logic             arrival_pulse;
        logic [5:0]       cursor_pad;
        logic [5:0]       target_pad;
    } out_item_t;

endpackage

// File: sv/xyg_mul.sv
`timescale 1ns / 1ps
// Shared multiplier used for squares, the step size and the move products.
module xyg_mul import xyg_pkg::*;
(
    input  logic [MA-1:0] a,
    input  logic [MB-1:0] b,
    output logic [MP-1:0] p
);

    // Plain unsigned product; the sequencer registers the result.
    assign p = MP'(a) * MP'(b);

endmodule

// File: sv/xyg_trial.sv
`timescale 1ns / 1ps
// Shared trial subtractor used by the square root and the divider.
module xyg_trial import xyg_pkg::*;
(
    input  logic [VW-1:0] a,
    input  logic [VW-1:0] b,
    output logic          ge,
    output logic [VW-1:0] diff
);

    // One compare and subtract per cycle.
    assign ge   = (a >= b);
    assign diff = a - b;

endmodule

// File: sv/xy_pad_vector_glide.sv
`timescale 1ns / 1ps
// Top level: XY pad cursor that glides toward a pad target at a chosen rate.
//
// Input requests carry a kind (tick, pad press or scene press), an index and
// a pressed flag. Every input request produces exactly one output request
// with the cursor position, the arrival pulse and the pad numbers of the
// cursor and the target.
// Pad presses, scene presses and ignored kinds go from idle straight to the
// output state, S_OUT; the next request is taken once S_OUT has published.
// A tick runs a sequencer around one multiplier and one trial subtractor.
// It runs the setup states S_DIFF, S_SQX, S_SQY and S_STEP, POS_W square
// root iterations and one check. When the cursor moves without snapping,
// S_MULX, two POS_W-iteration divisions split by S_MULY, and S_APPLY follow.
// Every tick then passes S_ARRIVE and S_OUT. One request is in flight at a
// time: no new request is taken until the result is published.
// The configuration channel is always ready; index 0 writes tick_period and
// index 1 writes pulse_ticks. Writes are expected only while idle.
// Reset puts the cursor and target at the origin, selects rate two and
// restores the register defaults. When the receiver stalls, the result
// holds in the output register and the block waits before finishing the
// next request.
module xy_pad_vector_glide import xyg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_SQX, S_SQY, S_STEP, S_SQRT, S_CHECK,
        S_MULX, S_DIVX, S_MULY, S_DIVY, S_APPLY, S_ARRIVE, S_OUT
    } state_t;

    // Target coordinate of grid column n: round(n * ONE / 7), half up.
    function automatic logic [POS_W-1:0] grid_coord(input int n);
        longint v;
        v = ((longint'(n) << (POS_FRAC_BITS + 1)) + 64'sd7) / 64'sd14;
        return v[POS_W-1:0];
    endfunction

    localparam logic [POS_W-1:0] GRID [8] = '{
        grid_coord(0), grid_coord(1), grid_coord(2), grid_coord(3),
        grid_coord(4), grid_coord(5), grid_coord(6), grid_coord(7)
    };

    // Nearest grid line of a coordinate, rounding half up, clamped to 7.
    function automatic logic [2:0] pad_round(input logic [POS_W-1:0] p);
        logic [POS_W+2:0] t;
        logic [POS_W+2:0] r;
        t = ({3'b0, p} << 3) - {3'b0, p}
            + ((POS_W + 3)'(1) << (POS_FRAC_BITS - 1));
        r = t >> POS_FRAC_BITS;
        return (r > (POS_W + 3)'(7)) ? 3'd7 : r[2:0];
    endfunction

    function automatic logic [5:0] pad_of(input logic [POS_W-1:0] x,
                                          input logic [POS_W-1:0] y);
        logic [2:0] ry;
        ry = pad_round(y);
        return {3'd7 - ry, pad_round(x)};
    endfunction

    state_t             state_reg;
    logic [31:0]        tick_period_reg;
    logic [15:0]        pulse_ticks_reg;
    logic [POS_W-1:0]   pos_x_reg, pos_y_reg, goal_x_reg, goal_y_reg;
    logic               awaiting_reg;
    logic [2:0]         rate_choice_reg;
    logic [15:0]        pulse_left_reg;
    logic               tick_reg;
    logic [POS_W-1:0]   ax_reg, ay_reg;
    logic [VW-1:0]      sq_reg, v_reg, res_reg, bit_reg;
    logic [SW-1:0]      step_reg;
    logic [POS_W-1:0]   rem_reg, low_reg, q_reg, mx_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic [MA-1:0]      mul_a;
    logic [MB-1:0]      mul_b;
    logic [MP-1:0]      mul_p;
    logic [VW-1:0]      tr_a, tr_b, tr_diff;
    logic               tr_ge;
    logic [POS_W:0]     div_r2;
    logic [POS_W-1:0]   dist_val;
    logic [SW-1:0]      step_raw;
    logic [POS_W-1:0]   mx, my;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign dist_val = res_reg[POS_W-1:0];
    assign div_r2   = {rem_reg, low_reg[POS_W-1]};
    assign step_raw = mul_p[STEP_SHIFT +: SW];

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            S_SQX:
            begin
                mul_a = MA'(ax_reg);
                mul_b = MB'(ax_reg);
            end
            S_SQY:
            begin
                mul_a = MA'(ay_reg);
                mul_b = MB'(ay_reg);
            end
            S_STEP:
            begin
                mul_a = tick_period_reg;
                mul_b = MB'(RATE_Q4[rate_choice_reg]);
            end
            S_MULX:
            begin
                mul_a = MA'(ax_reg);
                mul_b = MB'(step_reg[POS_W-1:0]);
            end
            S_MULY:
            begin
                mul_a = MA'(ay_reg);
                mul_b = MB'(step_reg[POS_W-1:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Operand selection for the shared trial subtractor.
    always_comb
    begin
        case (state_reg)
            S_SQRT:
            begin
                tr_a = v_reg;
                tr_b = res_reg + bit_reg;
            end
            S_DIVX, S_DIVY:
            begin
                tr_a = VW'(div_r2);
                tr_b = VW'(dist_val);
            end
            default:
            begin
                tr_a = '0;
                tr_b = '0;
            end
        endcase
    end

    xyg_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    xyg_trial u_trial (
        .a    (tr_a),
        .b    (tr_b),
        .ge   (tr_ge),
        .diff (tr_diff)
    );

    // Final move magnitudes, with the one-LSB nudge when both truncate to zero.
    always_comb
    begin
        mx = mx_reg;
        my = q_reg;
        if (mx_reg == '0 && q_reg == '0)
        begin
            if (ax_reg >= ay_reg)
            begin
                mx = POS_W'(1);
            end
            else
            begin
                my = POS_W'(1);
            end
        end
    end

    // Sequencer, state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            tick_period_reg <= TICK_PERIOD_RESET;
            pulse_ticks_reg <= PULSE_TICKS_RESET;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            goal_x_reg      <= '0;
            goal_y_reg      <= '0;
            awaiting_reg    <= 1'b0;
            rate_choice_reg <= RATE_CHOICE_RESET;
            pulse_left_reg  <= '0;
            tick_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_TICK_PERIOD: tick_period_reg <= cfg_data;
                    REG_PULSE_TICKS: pulse_ticks_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        tick_reg <= (in_data.kind == KIND_TICK);
                        if (in_data.kind == KIND_TICK)
                        begin
                            state_reg <= S_DIFF;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                            if (in_data.kind == KIND_PAD && in_data.pressed)
                            begin
                                goal_x_reg   <= GRID[in_data.index[2:0]];
                                goal_y_reg   <= GRID[~in_data.index[5:3]];
                                awaiting_reg <= 1'b1;
                            end
                            else if (in_data.kind == KIND_SCENE && in_data.pressed
                                     && in_data.index[5:3] == 3'd0)
                            begin
                                rate_choice_reg <= in_data.index[2:0];
                            end
                        end
                    end
                end
                S_DIFF:
                begin
                    ax_reg <= (goal_x_reg >= pos_x_reg) ? goal_x_reg - pos_x_reg
                                                         : pos_x_reg - goal_x_reg;
                    ay_reg <= (goal_y_reg >= pos_y_reg) ? goal_y_reg - pos_y_reg
                                                         : pos_y_reg - goal_y_reg;
                    state_reg <= S_SQX;
                end
                S_SQX:
                begin
                    sq_reg    <= mul_p[VW-1:0];
                    state_reg <= S_SQY;
                end
                S_SQY:
                begin
                    v_reg     <= sq_reg + mul_p[VW-1:0];
                    res_reg   <= '0;
                    bit_reg   <= VW'(1) << (VW - 2);
                    cnt_reg   <= '0;
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    step_reg  <= (step_raw == '0) ? SW'(1) : step_raw;
                    state_reg <= S_SQRT;
                end
                // One result bit of the integer square root per cycle.
                S_SQRT:
                begin
                    if (tr_ge)
                    begin
                        v_reg   <= tr_diff;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(POS_W - 1))
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (dist_val == '0)
                    begin
                        state_reg <= S_ARRIVE;
                    end
                    else if (step_reg >= SW'(dist_val))
                    begin
                        pos_x_reg <= goal_x_reg;
                        pos_y_reg <= goal_y_reg;
                        state_reg <= S_ARRIVE;
                    end
                    else
                    begin
                        state_reg <= S_MULX;
                    end
                end
                // Load a dividend, whose high half is already below the divisor; S_MULY also saves the X quotient.
                S_MULX, S_MULY:
                begin
                    rem_reg   <= mul_p[VW-1:POS_W];
                    low_reg   <= mul_p[POS_W-1:0];
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    if (state_reg == S_MULY)
                    begin
                        mx_reg    <= q_reg;
                        state_reg <= S_DIVY;
                    end
                    else
                    begin
                        state_reg <= S_DIVX;
                    end
                end
                // Restoring division, one quotient bit per cycle.
                S_DIVX, S_DIVY:
                begin
                    rem_reg <= tr_ge ? tr_diff[POS_W-1:0] : div_r2[POS_W-1:0];
                    low_reg <= low_reg << 1;
                    q_reg   <= {q_reg[POS_W-2:0], tr_ge};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(POS_W - 1))
                    begin
                        state_reg <= (state_reg == S_DIVX) ? S_MULY : S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    pos_x_reg <= (goal_x_reg >= pos_x_reg) ? pos_x_reg + mx
                                                            : pos_x_reg - mx;
                    pos_y_reg <= (goal_y_reg >= pos_y_reg) ? pos_y_reg + my
                                                            : pos_y_reg - my;
                    state_reg <= S_ARRIVE;
                end
                // Arrival check starts or extends the pulse.
                S_ARRIVE:
                begin
                    if (awaiting_reg && pos_x_reg == goal_x_reg
                        && pos_y_reg == goal_y_reg)
                    begin
                        awaiting_reg <= 1'b0;
                        if (pulse_ticks_reg > pulse_left_reg)
                        begin
                            pulse_left_reg <= pulse_ticks_reg;
                        end
                    end
                    state_reg <= S_OUT;
                end
                // Publish the result once the output register is free.
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg          <= 1'b1;
                        out_reg.cursor_x       <= pos_x_reg;
                        out_reg.cursor_y       <= pos_y_reg;
                        out_reg.arrival_pulse  <= (pulse_left_reg != '0);
                        out_reg.cursor_pad     <= pad_of(pos_x_reg, pos_y_reg);
                        out_reg.target_pad     <= pad_of(goal_x_reg, goal_y_reg);
                        if (tick_reg && pulse_left_reg != '0)
                        begin
                            pulse_left_reg <= pulse_left_reg - 16'd1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
